/* rtl/uqmp_pkg.sv */
// shared types, character codes and key tables of the url query parser
package uqmp_pkg;

  localparam int unsigned MAX_REC = 4;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned DUR_W   = 24;
  localparam int unsigned ADDR_W  = 3;

  localparam logic [DUR_W-1:0] DUR_LIMIT_RESET = 24'd8640000;

  // register index on the apb port
  localparam logic REG_DURATION_LIMIT = 1'b0;

  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PCT   = 8'h25;

  typedef enum logic [3:0] {
    PH_PRE  = 4'b0001,
    PH_KEY  = 4'b0010,
    PH_VAL  = 4'b0100,
    PH_DONE = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    TG_NONE   = 3'd0,
    TG_TITLE  = 3'd1,
    TG_AUTHOR = 3'd2,
    TG_DUR    = 3'd3,
    TG_FORM   = 3'd4
  } tgt_e;

  typedef enum logic [1:0] {
    REC_START   = 2'd0,
    REC_BYTE    = 2'd1,
    REC_SUMMARY = 2'd2
  } rec_kind_e;

  typedef struct packed {
    logic [7:0] url_byte;
    logic       end_of_url;
  } item_t;

  typedef struct packed {
    rec_kind_e  kind;
    logic       target;
    logic [7:0] data;
  } rec_t;

  typedef struct packed {
    rec_t [MAX_REC-1:0] recs;
    logic [CNT_W-1:0]   count;
    logic [DUR_W-1:0]   dur;
    logic               live;
  } res_t;

  function automatic logic [3:0] key_len(logic [1:0] k);
    logic [3:0] n;
    case (k)
      2'd0:    n = 4'd5;
      2'd1:    n = 4'd6;
      2'd2:    n = 4'd8;
      default: n = 4'd4;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] key_byte(logic [1:0] k, logic [2:0] pos);
    logic [63:0] s;
    case (k)
      2'd0:    s = {"title", 24'h0};
      2'd1:    s = {"author", 16'h0};
      2'd2:    s = "duration";
      default: s = {"form", 32'h0};
    endcase
    return s[63 - 8*pos -: 8];
  endfunction

  function automatic tgt_e key_target(logic [1:0] k);
    tgt_e t;
    case (k)
      2'd0:    t = TG_TITLE;
      2'd1:    t = TG_AUTHOR;
      2'd2:    t = TG_DUR;
      default: t = TG_FORM;
    endcase
    return t;
  endfunction

  function automatic tgt_e resolve_key(logic [3:0] cand, logic [3:0] pos);
    tgt_e t;
    logic found;
    t = TG_NONE;
    found = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (!found && cand[k] && pos == key_len(2'(k))) begin
        t = key_target(2'(k));
        found = 1'b1;
      end
    end
    return t;
  endfunction

  function automatic logic [7:0] live_byte(logic [1:0] pos);
    logic [31:0] s;
    s = "live";
    return s[31 - 8*pos -: 8];
  endfunction

  function automatic logic hex_ok(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  // only meaningful for hex digits
  function automatic logic [3:0] hex_nib(logic [7:0] c);
    return (c <= "9") ? c[3:0] : c[3:0] + 4'd9;
  endfunction

endpackage

/* rtl/url_query_meta_parser.sv */
// a taken byte waits in the input register until the result register can load it
// throughput: one url byte per cycle while out_ready_i is high; a byte with several
// records holds the input until the result register, one record a cycle, drains them
// reset: asynchronous, all parser state cleared, duration limit back to 8640000,
// ready right after reset with no clearing pass
module url_query_meta_parser import uqmp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // apb configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // url byte requests
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        url_byte_i,
  input  logic              end_of_url_i,
  // result records
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        record_kind_o,
  output logic              target_field_o,
  output logic [7:0]        data_byte_o,
  output logic [DUR_W-1:0]  duration_seconds_o,
  output logic              is_live_o,
  output logic              run_last_o
);

  logic [DUR_W-1:0] limit;
  item_t            item_q;
  logic             in_vld_q;
  logic             can_load;
  logic             fire;
  res_t             res;

  // the input register moves into the result register whenever that one
  // is empty or hands out its last record in this cycle
  assign fire       = in_vld_q && can_load;
  assign in_ready_o = !in_vld_q || can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{url_byte: url_byte_i, end_of_url: end_of_url_i};
    end
  end

  uqmp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  // phase, key match, escape and value tracking; commits on fire
  uqmp_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_q),
    .fire_i  (fire),
    .limit_i (limit),
    .res_o   (res)
  );

  // up to four records per byte drained one per cycle while out_ready_i is high
  uqmp_out u_out (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .res_i              (res),
    .load_i             (fire),
    .can_load_o         (can_load),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .record_kind_o      (record_kind_o),
    .target_field_o     (target_field_o),
    .data_byte_o        (data_byte_o),
    .duration_seconds_o (duration_seconds_o),
    .is_live_o          (is_live_o),
    .run_last_o         (run_last_o)
  );

  // the summary always closes the records of its byte
  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_kind_o == REC_SUMMARY |-> run_last_o)
    else $error("summary record not marked last");

  // only value bytes carry data
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_kind_o != REC_BYTE |-> data_byte_o == 8'h0)
    else $error("data byte set on a non-byte record");

  // summary fields stay clear outside the summary
  a_summary_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_kind_o != REC_SUMMARY |-> duration_seconds_o == '0 && !is_live_o)
    else $error("summary fields set on a value record");

  // a stalled record blocks the move from the input register
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !fire)
    else $error("result register overwritten while stalled");

endmodule

/* rtl/uqmp_cfg.sv */
// apb register block holding the duration limit
module uqmp_cfg import uqmp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [DUR_W-1:0]  limit_o
);

  logic [DUR_W-1:0] limit_q;
  logic             hit;

  assign hit    = (paddr[2] == REG_DURATION_LIMIT);
  assign pready = 1'b1;
  assign prdata = hit ? {8'h0, limit_q} : 32'h0;
  assign limit_o = limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= DUR_LIMIT_RESET;
    end else if (psel && penable && pwrite && hit) begin
      limit_q <= pwdata[DUR_W-1:0];
    end
  end

endmodule

/* rtl/uqmp_core.sv */
// parser state and the single-pass step logic for one url byte
module uqmp_core import uqmp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  item_t            item_i,
  input  logic             fire_i,
  input  logic [DUR_W-1:0] limit_i,
  output res_t             res_o
);

  phase_e           phase_q, phase_d;
  logic [3:0]       kpos_q, kpos_d;
  logic [3:0]       kcand_q, kcand_d;
  tgt_e             tgt_q, tgt_d;
  logic [1:0]       esc_q, esc_d;
  logic [7:0]       held_q, held_d;
  logic [DUR_W-1:0] acc_q, acc_d;
  logic             dok_q, dok_d;
  logic [2:0]       lpos_q, lpos_d;
  logic             lok_q, lok_d;
  logic [DUR_W-1:0] dsav_q, dsav_d;
  logic             lsav_q, lsav_d;

  logic [7:0]       c;
  logic             last;
  logic [2:0][7:0]  cb;
  logic [1:0]       cn;
  logic             st_go;
  tgt_e             st_t;
  logic             ep;
  logic             ep_delim;
  logic             en_go;
  phase_e           ph_after;
  tgt_e             tgt_cur;
  logic [27:0]      dur_mul;
  rec_t [MAX_REC-1:0] recs;
  logic [CNT_W-1:0] rn;

  always_comb begin
    phase_d  = phase_q;
    kpos_d   = kpos_q;
    kcand_d  = kcand_q;
    tgt_d    = tgt_q;
    esc_d    = esc_q;
    held_d   = held_q;
    acc_d    = acc_q;
    dok_d    = dok_q;
    lpos_d   = lpos_q;
    lok_d    = lok_q;
    dsav_d   = dsav_q;
    lsav_d   = lsav_q;
    c        = item_i.url_byte;
    last     = item_i.end_of_url;
    cb       = '0;
    cn       = '0;
    st_go    = 1'b0;
    st_t     = TG_NONE;
    ep       = 1'b0;
    ep_delim = 1'b0;
    en_go    = 1'b0;
    ph_after = phase_q;
    dur_mul  = '0;
    recs     = '0;
    rn       = '0;

    unique case (phase_q) inside
      PH_PRE: begin
        if (c == CH_QUEST) begin
          phase_d = PH_KEY;
          kpos_d  = '0;
          kcand_d = '1;
        end
      end
      PH_KEY, PH_VAL: begin
        if (c == CH_HASH || c == CH_AMP) begin
          ep       = 1'b1;
          ep_delim = 1'b1;
          ph_after = (c == CH_HASH) ? PH_DONE : PH_KEY;
        end else if (phase_q == PH_KEY) begin
          if (c == CH_EQ) begin
            st_go   = 1'b1;
            st_t    = resolve_key(kcand_q, kpos_q);
            esc_d   = '0;
            held_d  = '0;
            phase_d = PH_VAL;
          end else begin
            for (int k = 0; k < 4; k++) begin
              if (!(kpos_q < key_len(2'(k)) && c == key_byte(2'(k), kpos_q[2:0]))) begin
                kcand_d[k] = 1'b0;
              end
            end
            if (kpos_q != 4'hF) begin
              kpos_d = kpos_q + 4'd1;
            end
          end
        end else begin
          // value byte with percent decoding
          if (esc_q == 2'd1 && hex_ok(c)) begin
            held_d = c;
            esc_d  = 2'd2;
          end else if (esc_q == 2'd2 && hex_ok(c)) begin
            cb[cn] = {hex_nib(held_q), hex_nib(c)};
            cn     = cn + 2'd1;
            esc_d  = '0;
          end else begin
            // broken escape flushes literally, then c is rescanned
            if (esc_q == 2'd1 || esc_q == 2'd2) begin
              cb[cn] = CH_PCT;
              cn     = cn + 2'd1;
            end
            if (esc_q == 2'd2) begin
              cb[cn] = held_q;
              cn     = cn + 2'd1;
            end
            if (c == CH_PCT) begin
              esc_d = 2'd1;
            end else begin
              esc_d  = '0;
              cb[cn] = c;
              cn     = cn + 2'd1;
            end
          end
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (last && (phase_d == PH_KEY || phase_d == PH_VAL)) begin
      ep = 1'b1;
    end

    // pair end
    if (ep) begin
      if (phase_d == PH_KEY) begin
        st_go  = 1'b1;
        st_t   = resolve_key(kcand_d, kpos_d);
        en_go  = 1'b1;
      end else if (phase_d == PH_VAL) begin
        en_go = 1'b1;
        if (esc_d == 2'd1 || esc_d == 2'd2) begin
          cb[cn] = CH_PCT;
          cn     = cn + 2'd1;
        end
        if (esc_d == 2'd2) begin
          cb[cn] = held_d;
          cn     = cn + 2'd1;
        end
      end
      kpos_d  = '0;
      kcand_d = '1;
      if (ep_delim) begin
        phase_d = ph_after;
      end
    end

    tgt_cur = st_go ? st_t : tgt_q;

    if (st_go && st_t == TG_DUR) begin
      acc_d = '0;
      dok_d = 1'b1;
    end
    if (st_go && st_t == TG_FORM) begin
      lpos_d = '0;
      lok_d  = 1'b1;
    end

    // duration: a multi-byte consume always starts with a literal percent
    if (tgt_cur == TG_DUR && cn != 2'd0) begin
      // acc * 10 + digit, only used when one byte is consumed
      dur_mul = {1'b0, acc_q, 3'b0} + {3'b0, acc_q, 1'b0} + {24'h0, cb[0][3:0]};
      if (cn != 2'd1) begin
        dok_d = 1'b0;
      end else if (dok_q) begin
        if (cb[0] < "0" || cb[0] > "9") begin
          dok_d = 1'b0;
        end else if (dur_mul > {4'h0, limit_i}) begin
          dok_d = 1'b0;
        end else begin
          acc_d = dur_mul[DUR_W-1:0];
        end
      end
    end

    if (tgt_cur == TG_FORM) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < cn) begin
          if (lok_d && lpos_d < 3'd4 && cb[i] == live_byte(lpos_d[1:0])) begin
            lpos_d = lpos_d + 3'd1;
          end else begin
            lok_d = 1'b0;
          end
        end
      end
    end

    if (en_go) begin
      if (tgt_cur == TG_DUR) begin
        dsav_d = dok_d ? acc_d : '0;
      end
      if (tgt_cur == TG_FORM) begin
        lsav_d = lok_d && lpos_d == 3'd4;
      end
      tgt_d  = TG_NONE;
      esc_d  = '0;
      held_d = '0;
    end else if (st_go) begin
      tgt_d = st_t;
    end

    // result records
    if (st_go && (st_t == TG_TITLE || st_t == TG_AUTHOR)) begin
      recs[0] = '{kind: REC_START, target: (st_t == TG_AUTHOR), data: 8'h0};
      rn      = 3'd1;
    end
    if (tgt_cur == TG_TITLE || tgt_cur == TG_AUTHOR) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < cn) begin
          recs[i] = '{kind: REC_BYTE, target: (tgt_cur == TG_AUTHOR), data: cb[i]};
        end
      end
      rn = rn + {1'b0, cn};
    end
    if (last) begin
      recs[rn[1:0]] = '{kind: REC_SUMMARY, target: 1'b0, data: 8'h0};
      rn            = rn + 3'd1;
    end

    res_o.recs  = recs;
    res_o.count = rn;
    res_o.dur   = dsav_d;
    res_o.live  = lsav_d;

    // a new url starts from scratch
    if (last) begin
      phase_d = PH_PRE;
      kpos_d  = '0;
      kcand_d = '1;
      tgt_d   = TG_NONE;
      esc_d   = '0;
      held_d  = '0;
      acc_d   = '0;
      dok_d   = 1'b0;
      lpos_d  = '0;
      lok_d   = 1'b0;
      dsav_d  = '0;
      lsav_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PRE;
      kpos_q  <= '0;
      kcand_q <= '1;
      tgt_q   <= TG_NONE;
      esc_q   <= '0;
      held_q  <= '0;
      acc_q   <= '0;
      dok_q   <= 1'b0;
      lpos_q  <= '0;
      lok_q   <= 1'b0;
      dsav_q  <= '0;
      lsav_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      kpos_q  <= kpos_d;
      kcand_q <= kcand_d;
      tgt_q   <= tgt_d;
      esc_q   <= esc_d;
      held_q  <= held_d;
      acc_q   <= acc_d;
      dok_q   <= dok_d;
      lpos_q  <= lpos_d;
      lok_q   <= lok_d;
      dsav_q  <= dsav_d;
      lsav_q  <= lsav_d;
    end
  end

endmodule

/* rtl/uqmp_out.sv */
// result register that hands out the records of one byte, one per cycle while out_ready_i is high
module uqmp_out import uqmp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  res_t             res_i,
  input  logic             load_i,
  output logic             can_load_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       record_kind_o,
  output logic             target_field_o,
  output logic [7:0]       data_byte_o,
  output logic [DUR_W-1:0] duration_seconds_o,
  output logic             is_live_o,
  output logic             run_last_o
);

  rec_t [MAX_REC-1:0] rec_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [1:0]         idx_q;
  logic [DUR_W-1:0]   dur_q;
  logic               live_q;
  rec_t               cur;
  logic               last_rec;
  logic               is_sum;

  assign cur         = rec_q[idx_q];
  assign out_valid_o = (cnt_q != '0);
  assign last_rec    = out_valid_o && ({1'b0, idx_q} == cnt_q - 3'd1);
  assign can_load_o  = !out_valid_o || (out_ready_i && last_rec);
  assign is_sum      = (cur.kind == REC_SUMMARY);

  assign record_kind_o      = cur.kind;
  assign target_field_o     = cur.target;
  assign data_byte_o        = cur.data;
  assign duration_seconds_o = is_sum ? dur_q : '0;
  assign is_live_o          = is_sum && live_q;
  assign run_last_o         = last_rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= res_i.count;
      idx_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      if (last_rec) begin
        cnt_q <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q  <= res_i.recs;
      dur_q  <= res_i.dur;
      live_q <= res_i.live;
    end
  end

endmodule
